// File: rtl/apr_pkg.sv
// Shared types and constants for the aging page replacement block.
// Used by apr_cell, apr_ctrl, aging_page_replacement, the checker and the testbench; depends on nothing.
package apr_pkg;

    // Fixed field widths of the external interface.
    localparam int PAGE_NUM_W  = 16;
    localparam int FRAME_OUT_W = 4;
    localparam int LIMIT_W     = 5;
    localparam int TOTAL_W     = 32;

    // Width of one aging counter.
    localparam int AGE_W = 8;

    // Reset value of the frame limit register.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    // Commands broadcast from the controller to every frame cell.
    typedef struct packed {
        logic age_step;    // hit: set reference bits and age all filled frames
        logic write;       // miss: load the page into the selected frame
        logic scan_start;  // launch a minimum-search token at frame 0
    } apr_cmd_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_EVICT
    } apr_state_t;

endpackage

// File: rtl/apr_cell.sv
// One page frame: tag, aging counter and one stage of the victim search chain.
// Depends on apr_pkg for the command struct and the counter width.
module apr_cell
    import apr_pkg::*;
#(
    parameter int PAGE_BITS = 16,
    parameter int IDX_W     = 4,
    parameter int IDX       = 0
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  apr_cmd_t             cmd,
    input  logic [PAGE_BITS-1:0] page,
    input  logic [IDX_W-1:0]     wr_idx,
    input  logic                 filled,
    input  logic                 in_range,
    input  logic                 prev_valid,
    input  logic [AGE_W-1:0]     prev_age,
    input  logic [IDX_W-1:0]     prev_idx,
    input  logic [PAGE_BITS-1:0] prev_tag,
    output logic                 match,
    output logic                 scan_valid,
    output logic [AGE_W-1:0]     scan_age,
    output logic [IDX_W-1:0]     scan_idx,
    output logic [PAGE_BITS-1:0] scan_tag
);

    logic [PAGE_BITS-1:0] tag_reg, tag_next;
    logic [AGE_W-1:0]     age_reg, age_next;
    logic                 scan_valid_reg, scan_valid_next;
    logic [AGE_W-1:0]     scan_age_reg, scan_age_next;
    logic [IDX_W-1:0]     scan_idx_reg, scan_idx_next;
    logic [PAGE_BITS-1:0] scan_tag_reg, scan_tag_next;
    logic                 sel;
    logic                 start;

    // Tag compare against the page under lookup; only filled frames count.
    assign match = filled && (tag_reg == page);
    assign sel   = (wr_idx == IDX_W'(IDX));
    assign start = cmd.scan_start && (IDX == 0);

    // Frame update. The reference bit of this frame is the match itself,
    // and it goes straight into the top bit of the shifted counter.
    always_comb
    begin
        tag_next = tag_reg;
        age_next = age_reg;
        if (cmd.write && sel)
        begin
            tag_next = page;
            age_next = '0;
        end
        else if (cmd.age_step && filled)
        begin
            age_next = {match, age_reg[AGE_W-1:1]};
        end
    end

    // Search chain stage. The token keeps the smallest counter seen so far;
    // on a tie the earlier (lower index) frame stays in front.
    always_comb
    begin
        scan_valid_next = in_range && (start || prev_valid);
        if (start || (prev_valid && (age_reg < prev_age)))
        begin
            scan_age_next = age_reg;
            scan_idx_next = IDX_W'(IDX);
            scan_tag_next = tag_reg;
        end
        else
        begin
            scan_age_next = prev_age;
            scan_idx_next = prev_idx;
            scan_tag_next = prev_tag;
        end
    end

    // Token valid bit is control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_valid_reg <= 1'b0;
        end
        else
        begin
            scan_valid_reg <= scan_valid_next;
        end
    end

    // Frame contents and token payload need no reset.
    always_ff @(posedge clk)
    begin
        tag_reg      <= tag_next;
        age_reg      <= age_next;
        scan_age_reg <= scan_age_next;
        scan_idx_reg <= scan_idx_next;
        scan_tag_reg <= scan_tag_next;
    end

    assign scan_valid = scan_valid_reg;
    assign scan_age   = scan_age_reg;
    assign scan_idx   = scan_idx_reg;
    assign scan_tag   = scan_tag_reg;

endmodule

// File: rtl/apr_ctrl.sv
// Sequencer for the aging page replacement block: handshakes, fill count,
// hit and miss totals, frame limit register and the result register. Uses apr_pkg.
module apr_ctrl
    import apr_pkg::*;
#(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16,
    parameter int IDX_W     = 4,
    parameter int CNT_W     = 5
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [PAGE_NUM_W-1:0]  page_number,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   hit,
    output logic [FRAME_OUT_W-1:0] frame_index,
    output logic                   evicted,
    output logic [PAGE_NUM_W-1:0]  evicted_page,
    output logic [TOTAL_W-1:0]     hit_total,
    output logic [TOTAL_W-1:0]     miss_total,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [LIMIT_W-1:0]     frame_limit,
    input  logic                   hit_any,
    input  logic [IDX_W-1:0]       hit_idx,
    input  logic                   scan_done,
    input  logic [IDX_W-1:0]       victim_idx,
    input  logic [PAGE_BITS-1:0]   victim_tag,
    output apr_cmd_t               cmd,
    output logic [PAGE_BITS-1:0]   page,
    output logic [IDX_W-1:0]       wr_idx,
    output logic [CNT_W-1:0]       filled,
    output logic [CNT_W-1:0]       lim
);

    apr_state_t               state_reg, state_next;
    logic [PAGE_BITS-1:0]     page_reg, page_next;
    logic [CNT_W-1:0]         filled_reg, filled_next;
    logic [TOTAL_W-1:0]       hit_count_reg, hit_count_next;
    logic [TOTAL_W-1:0]       miss_count_reg, miss_count_next;
    logic [LIMIT_W-1:0]       limit_reg, limit_next;
    logic [IDX_W-1:0]         victim_idx_reg, victim_idx_next;
    logic [PAGE_BITS-1:0]     victim_tag_reg, victim_tag_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     hit_reg, hit_next;
    logic [FRAME_OUT_W-1:0]   frame_reg, frame_next;
    logic                     evicted_reg, evicted_next;
    logic [PAGE_NUM_W-1:0]    evicted_page_reg, evicted_page_next;
    logic                     out_free;
    logic                     load_out;

    // Effective limit: zero acts as one, anything above FRAMES saturates.
    always_comb
    begin
        if (limit_reg == '0)
        begin
            lim = CNT_W'(1);
        end
        else if (32'(limit_reg) > FRAMES)
        begin
            lim = CNT_W'(FRAMES);
        end
        else
        begin
            lim = CNT_W'(limit_reg);
        end
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // Next state, frame commands and result loading.
    always_comb
    begin
        state_next        = state_reg;
        page_next         = page_reg;
        filled_next       = filled_reg;
        hit_count_next    = hit_count_reg;
        miss_count_next   = miss_count_reg;
        limit_next        = limit_reg;
        victim_idx_next   = victim_idx_reg;
        victim_tag_next   = victim_tag_reg;
        hit_next          = hit_reg;
        frame_next        = frame_reg;
        evicted_next      = evicted_reg;
        evicted_page_next = evicted_page_reg;
        cmd               = '0;
        wr_idx            = victim_idx_reg;
        load_out          = 1'b0;

        if (cfg_valid)
        begin
            limit_next = frame_limit;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    page_next  = PAGE_BITS'(page_number);
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (hit_any)
                begin
                    // Hit: age every filled frame, count and report.
                    if (out_free)
                    begin
                        cmd.age_step      = 1'b1;
                        hit_count_next    = hit_count_reg + 32'd1;
                        load_out          = 1'b1;
                        hit_next          = 1'b1;
                        frame_next        = FRAME_OUT_W'(hit_idx);
                        evicted_next      = 1'b0;
                        evicted_page_next = '0;
                        state_next        = ST_IDLE;
                    end
                end
                else if (filled_reg < lim)
                begin
                    // Miss with a free frame: fill the next one in order.
                    wr_idx = IDX_W'(filled_reg);
                    if (out_free)
                    begin
                        cmd.write         = 1'b1;
                        filled_next       = filled_reg + CNT_W'(1);
                        miss_count_next   = miss_count_reg + 32'd1;
                        load_out          = 1'b1;
                        hit_next          = 1'b0;
                        frame_next        = FRAME_OUT_W'(filled_reg);
                        evicted_next      = 1'b0;
                        evicted_page_next = '0;
                        state_next        = ST_IDLE;
                    end
                end
                else
                begin
                    // Miss with no free frame: search for the oldest page.
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    victim_idx_next = victim_idx;
                    victim_tag_next = victim_tag;
                    state_next      = ST_EVICT;
                end
            end
            ST_EVICT:
            begin
                if (out_free)
                begin
                    cmd.write         = 1'b1;
                    miss_count_next   = miss_count_reg + 32'd1;
                    load_out          = 1'b1;
                    hit_next          = 1'b0;
                    frame_next        = FRAME_OUT_W'(victim_idx_reg);
                    evicted_next      = 1'b1;
                    evicted_page_next = PAGE_NUM_W'(victim_tag_reg);
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            filled_reg     <= '0;
            hit_count_reg  <= '0;
            miss_count_reg <= '0;
            limit_reg      <= LIMIT_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            filled_reg     <= filled_next;
            hit_count_reg  <= hit_count_next;
            miss_count_reg <= miss_count_next;
            limit_reg      <= limit_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        page_reg         <= page_next;
        victim_idx_reg   <= victim_idx_next;
        victim_tag_reg   <= victim_tag_next;
        hit_reg          <= hit_next;
        frame_reg        <= frame_next;
        evicted_reg      <= evicted_next;
        evicted_page_reg <= evicted_page_next;
    end

    assign page         = page_reg;
    assign filled       = filled_reg;
    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign frame_index  = frame_reg;
    assign evicted      = evicted_reg;
    assign evicted_page = evicted_page_reg;
    assign hit_total    = hit_count_reg;
    assign miss_total   = miss_count_reg;

`ifndef SYNTHESIS
    // The totals move only when a new beat is loaded into a free result slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=>
            ($stable(hit_count_reg) && $stable(miss_count_reg)))
        else $error("totals changed while a result beat was waiting");

    // A hit that finds the result slot free is counted once.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOKUP && hit_any && out_free) |=>
            (hit_count_reg == $past(hit_count_reg) + 32'd1))
        else $error("hit not counted");

    // The search chain reports only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        scan_done |-> (state_reg == ST_SCAN))
        else $error("stray search result");

    // The fill count never runs past the number of frames.
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(filled_reg) <= FRAMES)
        else $error("fill count beyond frame count");
`endif

endmodule

// File: rtl/aging_page_replacement.sv
// A hit, or a miss into a free frame, is resolved in ST_LOOKUP, which loads its result beat once
// the result slot is free. A miss with all frames in use runs a victim search token down the first
// lim cells, one frame per cycle, lim being the effective frame limit; ST_SCAN waits for the
// result and ST_EVICT writes the page once the result slot is free. One reference is in flight
// at a time: a new beat is taken only in ST_IDLE, after the result of the last one is loaded.
// Reset (async, active low) clears the counters, the fill count and sets the limit to 16;
// frame tags and counters are not cleared, since only filled frames are ever read.
module aging_page_replacement
    import apr_pkg::*;
#(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [PAGE_NUM_W-1:0]  page_number,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   hit,
    output logic [FRAME_OUT_W-1:0] frame_index,
    output logic                   evicted,
    output logic [PAGE_NUM_W-1:0]  evicted_page,
    output logic [TOTAL_W-1:0]     hit_total,
    output logic [TOTAL_W-1:0]     miss_total,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [LIMIT_W-1:0]     frame_limit
);

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);

    apr_cmd_t             cmd;
    logic [PAGE_BITS-1:0] page;
    logic [IDX_W-1:0]     wr_idx;
    logic [CNT_W-1:0]     filled;
    logic [CNT_W-1:0]     lim;
    logic                 hit_any;
    logic [IDX_W-1:0]     hit_idx;
    logic                 scan_done;
    logic [IDX_W-1:0]     victim_idx;
    logic [PAGE_BITS-1:0] victim_tag;

    logic [FRAMES-1:0]    match_vec;
    logic [FRAMES-1:0]    done_vec;
    logic [FRAMES-1:0]    scan_v;
    logic [AGE_W-1:0]     scan_age [FRAMES];
    logic [IDX_W-1:0]     scan_idx [FRAMES];
    logic [PAGE_BITS-1:0] scan_tag [FRAMES];

    apr_ctrl #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .page_number  (page_number),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit),
        .frame_index  (frame_index),
        .evicted      (evicted),
        .evicted_page (evicted_page),
        .hit_total    (hit_total),
        .miss_total   (miss_total),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .frame_limit  (frame_limit),
        .hit_any      (hit_any),
        .hit_idx      (hit_idx),
        .scan_done    (scan_done),
        .victim_idx   (victim_idx),
        .victim_tag   (victim_tag),
        .cmd          (cmd),
        .page         (page),
        .wr_idx       (wr_idx),
        .filled       (filled),
        .lim          (lim)
    );

    // Row of frame cells; each passes its search token to the next one.
    for (genvar i = 0; i < FRAMES; i++)
    begin : g_cell
        logic                 prev_valid;
        logic [AGE_W-1:0]     prev_age;
        logic [IDX_W-1:0]     prev_idx;
        logic [PAGE_BITS-1:0] prev_tag;
        logic                 filled_i;
        logic                 in_range_i;

        if (i == 0)
        begin : g_head
            assign prev_valid = 1'b0;
            assign prev_age   = '0;
            assign prev_idx   = '0;
            assign prev_tag   = '0;
        end
        else
        begin : g_link
            assign prev_valid = scan_v[i-1];
            assign prev_age   = scan_age[i-1];
            assign prev_idx   = scan_idx[i-1];
            assign prev_tag   = scan_tag[i-1];
        end

        assign filled_i    = (CNT_W'(i) < filled);
        assign in_range_i  = (CNT_W'(i) < lim);
        assign done_vec[i] = scan_v[i] && (CNT_W'(i + 1) == lim);

        apr_cell #(
            .PAGE_BITS (PAGE_BITS),
            .IDX_W     (IDX_W),
            .IDX       (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .page       (page),
            .wr_idx     (wr_idx),
            .filled     (filled_i),
            .in_range   (in_range_i),
            .prev_valid (prev_valid),
            .prev_age   (prev_age),
            .prev_idx   (prev_idx),
            .prev_tag   (prev_tag),
            .match      (match_vec[i]),
            .scan_valid (scan_v[i]),
            .scan_age   (scan_age[i]),
            .scan_idx   (scan_idx[i]),
            .scan_tag   (scan_tag[i])
        );
    end

    // Filled tags are distinct, so at most one cell matches and at most one
    // token finishes; both selections are plain AND-OR merges.
    always_comb
    begin
        hit_idx    = '0;
        victim_idx = '0;
        victim_tag = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            if (match_vec[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
            if (done_vec[i])
            begin
                victim_idx = victim_idx | scan_idx[i];
                victim_tag = victim_tag | scan_tag[i];
            end
        end
    end

    assign hit_any   = |match_vec;
    assign scan_done = |done_vec;

`ifndef SYNTHESIS
    // A page is resident in at most one frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("page resident in more than one frame");

    // Only the last frame within the limit reports a search result.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(done_vec))
        else $error("more than one search token finished");

    // A search only runs after a miss, so it never overlaps a match.
    assert property (@(posedge clk) disable iff (!rst_n)
        hit_any |-> !scan_done)
        else $error("search result during a hit");
`endif

endmodule

// File: verif/aging_page_replacement_checker.sv
// Result checker for the aging page replacement block: a predictor of the frame table.
// It watches the config, reference and result channels and compares every result beat.
// Depends on apr_pkg for the field widths.
module apr_reference_checker
    import apr_pkg::*;
#(
    parameter int FRAMES = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [PAGE_NUM_W-1:0]  page_number,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic                   hit,
    input  logic [FRAME_OUT_W-1:0] frame_index,
    input  logic                   evicted,
    input  logic [PAGE_NUM_W-1:0]  evicted_page,
    input  logic [TOTAL_W-1:0]     hit_total,
    input  logic [TOTAL_W-1:0]     miss_total,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [LIMIT_W-1:0]     frame_limit,
    output int                     fail_count,
    output int                     pending,
    output int                     hits_seen,
    output int                     evictions_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                   hit;
        logic [FRAME_OUT_W-1:0] frame;
        logic                   evicted;
        logic [PAGE_NUM_W-1:0]  victim;
        logic [TOTAL_W-1:0]     hits;
        logic [TOTAL_W-1:0]     misses;
    } page_result_t;

    page_result_t          expected_q [$];

    // Predicted frame table.
    logic [PAGE_NUM_W-1:0] tag_mem [FRAMES];
    logic [AGE_W-1:0]      age_mem [FRAMES];
    logic                  ref_mem [FRAMES];
    int                    used_frames;
    logic [TOTAL_W-1:0]    hit_tally;
    logic [TOTAL_W-1:0]    miss_tally;
    logic [LIMIT_W-1:0]    limit_reg;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    // Look the page up, update the table and queue the result it must produce.
    task automatic resolve_reference(input logic [PAGE_NUM_W-1:0] pg);
        page_result_t     r;
        int               i;
        int               slot;
        int               lim;
        bit               found;
        logic [AGE_W-1:0] oldest;
        r     = '0;
        found = 1'b0;
        slot  = 0;
        for (i = 0; i < used_frames; i++)
        begin
            if (!found && tag_mem[i] == pg)
            begin
                found = 1'b1;
                slot  = i;
            end
        end
        if (found)
        begin
            // A hit marks the frame referenced and ages every filled frame.
            r.hit     = 1'b1;
            hit_tally = hit_tally + 1;
            for (i = 0; i < used_frames; i++)
            begin
                ref_mem[i] = (i == slot);
                age_mem[i] = {ref_mem[i], age_mem[i][AGE_W-1:1]};
            end
        end
        else
        begin
            // A zero limit acts as one frame; a limit past the table saturates.
            lim        = (limit_reg == 0) ? 1 : int'(limit_reg);
            lim        = (lim > FRAMES) ? FRAMES : lim;
            miss_tally = miss_tally + 1;
            if (used_frames < lim)
            begin
                slot = used_frames;
                used_frames++;
            end
            else
            begin
                // The lowest index wins a tie on the smallest counter.
                oldest = age_mem[0];
                slot   = 0;
                for (i = 1; i < lim; i++)
                begin
                    if (age_mem[i] < oldest)
                    begin
                        oldest = age_mem[i];
                        slot   = i;
                    end
                end
                r.evicted = 1'b1;
                r.victim  = tag_mem[slot];
            end
            tag_mem[slot] = pg;
            age_mem[slot] = '0;
            ref_mem[slot] = 1'b1;
        end
        r.frame  = slot[FRAME_OUT_W-1:0];
        r.hits   = hit_tally;
        r.misses = miss_tally;
        expected_q.push_back(r);
    endtask

    // Compare one result beat with the oldest expectation, field by field.
    task automatic check_result();
        page_result_t want;
        if (expected_q.size() == 0)
        begin
            report_mismatch($sformatf("result beat with nothing outstanding (frame %0d)",
                                      frame_index));
        end
        else
        begin
            want = expected_q.pop_front();
            if (want.hit)
                hits_seen++;
            if (want.evicted)
                evictions_seen++;
            if (hit !== want.hit)
                report_mismatch($sformatf("hit got %0b want %0b", hit, want.hit));
            if (frame_index !== want.frame)
                report_mismatch($sformatf("frame_index got %0d want %0d",
                                          frame_index, want.frame));
            if (evicted !== want.evicted)
                report_mismatch($sformatf("evicted got %0b want %0b", evicted, want.evicted));
            if (evicted_page !== want.victim)
                report_mismatch($sformatf("evicted_page got 0x%04h want 0x%04h",
                                          evicted_page, want.victim));
            if (hit_total !== want.hits)
                report_mismatch($sformatf("hit_total got %0d want %0d", hit_total, want.hits));
            if (miss_total !== want.misses)
                report_mismatch($sformatf("miss_total got %0d want %0d",
                                          miss_total, want.misses));
        end
    endtask

    // Beats are taken in the order config, result, reference, so that a result
    // is never matched with a reference accepted on the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_q.delete();
            used_frames    = 0;
            hit_tally      = '0;
            miss_tally     = '0;
            limit_reg      = LIMIT_RESET;
            fail_count     = 0;
            hits_seen      = 0;
            evictions_seen = 0;
            pending       <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                limit_reg = frame_limit;
            if (out_valid && out_ready)
                check_result();
            if (in_valid && in_ready)
                resolve_reference(page_number);
            pending <= expected_q.size();
        end
    end

endmodule

// File: verif/aging_page_replacement_tb.sv
// Testbench top for the aging page replacement block: clock, reset, stimulus and verdict.
// Depends on apr_pkg, the block itself and apr_reference_checker.
module aging_page_replacement_tb
    import apr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_PHASE = 115;
    localparam int FIXED_PHASES    = 12;
    localparam int RANDOM_PHASES   = 4;
    localparam int DRAIN_CYCLES    = 40;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [PAGE_NUM_W-1:0]  page_number;
    logic                   out_valid;
    logic                   out_ready;
    logic                   hit;
    logic [FRAME_OUT_W-1:0] frame_index;
    logic                   evicted;
    logic [PAGE_NUM_W-1:0]  evicted_page;
    logic [TOTAL_W-1:0]     hit_total;
    logic [TOTAL_W-1:0]     miss_total;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [LIMIT_W-1:0]     frame_limit;

    int fail_count;
    int pending;
    int hits_seen;
    int evictions_seen;
    int refs_sent;
    bit send_calm;
    bit recv_calm;

    // Extremes, hits on both ends of the page range, a full table, then evictions.
    logic [PAGE_NUM_W-1:0] directed_pages [0:20] = '{
        16'h0000, 16'hFFFF, 16'h0000, 16'h8000, 16'h0001, 16'hFFFF,
        16'h1000, 16'h1001, 16'h1002, 16'h1003, 16'h1004, 16'h1005,
        16'h1006, 16'h1007, 16'h1008, 16'h1009, 16'h100A, 16'h100B,
        16'h5555, 16'hAAAA, 16'h0000
    };

    // Limit settings: one frame, zero, the top code, the reset value and around it.
    logic [LIMIT_W-1:0] phase_limits [0:FIXED_PHASES-1] = '{
        5'd1, 5'd0, 5'd31, 5'd16, 5'd3, 5'd17, 5'd2, 5'd8, 5'd0, 5'd12, 5'd5, 5'd16
    };

    aging_page_replacement dut (.*);

    apr_reference_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #(2_000_000);
        $display("TEST FAILED");
        $finish;
    end

    // Result side: after each beat, hold ready low for a random stall, with calm stretches of no stall.
    initial
    begin : result_sink
        int hold;
        hold      = 0;
        out_ready = 1'b0;
        recv_calm = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if ($urandom_range(0, 39) == 0)
                    recv_calm = !recv_calm;
                hold = recv_calm ? 0 : $urandom_range(0, 3);
            end
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                hold--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Offer one reference beat after a random gap, if any; called on a clock edge.
    task automatic send_page(input logic [PAGE_NUM_W-1:0] pg);
        int gap;
        if ($urandom_range(0, 39) == 0)
            send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        page_number <= pg;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        refs_sent++;
    endtask

    // Drop valid and wait until every outstanding result has been taken.
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        cfg_valid   <= 1'b1;
        frame_limit <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    // Mostly references from a small working set, so that hits, aging and
    // replacement all happen; the rest are arbitrary pages and the range ends.
    task automatic run_phase(input logic [LIMIT_W-1:0] lim);
        logic [PAGE_NUM_W-1:0] pool [32];
        int                    pool_size;
        int                    k;
        int                    pick;
        write_limit(lim);
        pool_size = $urandom_range(2, 24);
        for (k = 0; k < pool_size; k++)
            pool[k] = PAGE_NUM_W'($urandom);
        for (k = 0; k < ITEMS_PER_PHASE; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 85)
                send_page(pool[$urandom_range(0, pool_size - 1)]);
            else if (pick < 95)
                send_page(PAGE_NUM_W'($urandom));
            else
                send_page($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
        end
        settle();
    endtask

    initial
    begin : stimulus
        int k;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        page_number = '0;
        cfg_valid   = 1'b0;
        frame_limit = '0;
        refs_sent   = 0;
        send_calm   = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed references at the reset limit.
        for (k = 0; k <= 20; k++)
            send_page(directed_pages[k]);
        settle();

        // Random references across the limit settings.
        for (k = 0; k < FIXED_PHASES; k++)
            run_phase(phase_limits[k]);
        for (k = 0; k < RANDOM_PHASES; k++)
            run_phase(LIMIT_W'($urandom_range(0, 31)));

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d page references over %0d frame-limit settings (0 to 31).",
                 refs_sent, FIXED_PHASES + RANDOM_PHASES);
        $display("Results checked: %0d hits, %0d evictions, %0d mismatches.",
                 hits_seen, evictions_seen, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
